/* rtl/fixed_length_frame_deframer_macros.svh */
// Assertion macros shared by the frame deframer modules.
`ifndef FIXED_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`define FIXED_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define FLD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("deframer check failed");
`define FLD_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("deframer forbidden condition");
`else
`define FLD_ASSERT(lbl, prop)
`define FLD_ASSERT_NEVER(lbl, expr)
`endif
`endif

/* rtl/fld_pkg.sv */
// Types and constants shared by the frame deframer modules.
package fld_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_FRAME_LENGTH = 2'd2;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hFB;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'hFE;
  localparam logic [CNT_W-1:0]  FRAME_LENGTH_RST = 7'd5;

  typedef struct packed {
    logic accept;
    logic start_emit;
    logic emit_en;
  } fld_cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic rd_done;
  } fld_sts_t;

endpackage

/* rtl/fld_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module fld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fld_ctrl.sv */
// Controller for the frame deframer: receive and emit phases.
`include "fixed_length_frame_deframer_macros.svh"

module fld_ctrl
  import fld_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rx_valid_i,
  output logic     rx_stall_o,
  input  fld_sts_t sts_i,
  output fld_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state_q, state_d;

  always_comb begin
    cmd_o.accept     = rx_valid_i && (state_q == S_IDLE);
    cmd_o.start_emit = cmd_o.accept && sts_i.frame_ok;
    cmd_o.emit_en    = (state_q == S_EMIT);
  end

  assign rx_stall_o = (state_q == S_EMIT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.start_emit) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.rd_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A good frame always holds at least two words, so reading cannot be done at once.
  `FLD_ASSERT(a_start_not_done, cmd_o.start_emit |=> !sts_i.rd_done)
  `FLD_ASSERT(a_start_enters_emit, cmd_o.start_emit |=> (state_q == S_EMIT))
  `FLD_ASSERT(a_done_leaves_emit, ((state_q == S_EMIT) && sts_i.rd_done) |=> (state_q == S_IDLE))

endmodule

/* rtl/fld_dp.sv */
// Datapath for the frame deframer: registers, frame store and output stage.
`include "fixed_length_frame_deframer_macros.svh"

module fld_dp
  import fld_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fld_cmd_t           cmd_i,
  output fld_sts_t           sts_o,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  frame_byte_o,
  output logic               last_byte_o
);

  localparam int unsigned AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam logic [CNT_W:0] MaxNext = (CNT_W + 1)'(MAX_FRAME);

  // Configuration registers.
  logic [BYTE_W-1:0] start_q, end_q;
  logic [CNT_W-1:0]  len_q;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_MARKER_RST;
      end_q   <= END_MARKER_RST;
      len_q   <= FRAME_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_MARKER: start_q <= pwdata[BYTE_W-1:0];
        REG_END_MARKER:   end_q   <= pwdata[BYTE_W-1:0];
        REG_FRAME_LENGTH: len_q   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_START_MARKER: prdata[BYTE_W-1:0] = start_q;
      REG_END_MARKER:   prdata[BYTE_W-1:0] = end_q;
      REG_FRAME_LENGTH: prdata[CNT_W-1:0]  = len_q;
      default:          prdata = '0;
    endcase
  end

  // Receive side: frame tracking.
  logic             in_frame_q, in_frame_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W:0]   next_cnt;
  logic             is_start, is_end, over;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  assign next_cnt = {1'b0, count_q} + (CNT_W + 1)'(1);
  assign is_start = (rx_byte_i == start_q);
  assign is_end   = (rx_byte_i == end_q);
  assign over     = (next_cnt > {1'b0, len_q}) || (next_cnt > MaxNext);

  assign sts_o.frame_ok = in_frame_q && !over && is_end && (next_cnt == {1'b0, len_q});

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    wr_en      = 1'b0;
    wr_addr    = '0;
    if (cmd_i.accept) begin
      if (!in_frame_q) begin
        if (is_start) begin
          wr_en      = 1'b1;
          in_frame_d = 1'b1;
          count_d    = CNT_W'(1);
        end
      end else if (over) begin
        in_frame_d = 1'b0;
        count_d    = '0;
      end else begin
        wr_en = 1'b1;
        if (is_end) begin
          wr_addr    = count_q[AW-1:0];
          in_frame_d = 1'b0;
          count_d    = '0;
        end else if (is_start) begin
          count_d = CNT_W'(1);
        end else begin
          wr_addr = count_q[AW-1:0];
          count_d = next_cnt[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
    end
  end

  // Emit side: read pointer, read in flight and output register.
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              pend_q, pend_last_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              rd_issue;
  logic [BYTE_W-1:0] rd_data;

  assign rd_issue = cmd_i.emit_en && !pend_q && (ptr_q != len_q)
                    && (!out_valid_q || !out_stall_i);
  assign sts_o.rd_done = (ptr_q == len_q) && !pend_q;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.start_emit) begin
      ptr_d = '0;
    end else if (rd_issue) begin
      ptr_d = ptr_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      pend_q <= rd_issue;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      pend_last_q <= ((ptr_q + CNT_W'(1)) == len_q);
    end
    if (pend_q) begin
      out_byte_q <= rd_data;
      out_last_q <= pend_last_q;
    end
  end

  fld_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (rx_byte_i),
    .re_i    (rd_issue),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

  `FLD_ASSERT_NEVER(a_no_write_in_emit, wr_en && cmd_i.emit_en)
  `FLD_ASSERT(a_read_lands, pend_q |=> out_valid_q)
  `FLD_ASSERT(a_read_in_frame, rd_issue |-> (ptr_q < len_q))

endmodule

/* rtl/fixed_length_frame_deframer.sv */
// Top level of the fixed-length frame deframer.
// The block takes a new word every cycle while no frame is being emitted. A frame of L words
// (L = frame_length) is read back from the frame store one word at a time, through the registered
// store read ahead of the single output register; a new read waits until the previous one has
// landed and while the output stalls. Input stays stalled from the end marker until all L are read.
// Reset is asynchronous and active low; it clears the control state and loads the default
// markers 0xFB and 0xFE and length 5. The frame store needs no clearing pass.
module fixed_length_frame_deframer
  import fld_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Received serial words.
  input  logic               rx_valid_i,
  output logic               rx_stall_o,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  // Words of accepted frames.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  frame_byte_o,
  output logic               last_byte_o,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // The controller only decides between taking received words and emitting a stored frame.
  // All counting, marker matching and the frame store itself live in the datapath.
  fld_cmd_t cmd;
  fld_sts_t sts;

  // Writes complete in their access cycle, so the port never waits.
  assign pready = 1'b1;

  fld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath tracks the frame as words come in, writes them into the store and, once a frame
  // of exactly the configured length closes, walks the store from the start marker onwards.
  fld_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rx_byte_i    (rx_byte_i),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule
